### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/ict_pkg.sv
package ict_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 64;

    localparam int DATE_W     = 22;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int IN_TDATA_W = 56;    // date and value, padded to whole bytes

    // Interpolation datapath widths.
    localparam int DIFF_W = VALUE_W + 1;        // va - vb
    localparam int PROD_W = DIFF_W + DATE_W + 1; // signed product
    localparam int MAG_W  = PROD_W - 1;          // magnitude of the product
    localparam int QUOT_W = VALUE_W + 1;         // quotient never exceeds |va - vb|

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 3'd0,
        ST_FULL       = 3'd1,
        ST_EXACT      = 3'd2,
        ST_INTERP     = 3'd3,
        ST_CLAMP_LOW  = 3'd4,
        ST_CLAMP_HIGH = 3'd5,
        ST_EMPTY      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD_ONE,
        S_GET_ONE,
        S_RD_VB,
        S_GET_VB,
        S_RD_VA,
        S_GET_VA,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_ADD,
        S_RESULT
    } state_t;

endpackage

### rtl/ict_ram.sv
module ict_ram #(
    parameter int WIDTH = ict_pkg::VALUE_W,
    parameter int DEPTH = ict_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/ict_div.sv
module ict_div #(
    parameter int DIVIDEND_W = ict_pkg::MAG_W,
    parameter int DIVISOR_W  = ict_pkg::DATE_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  rem_ge;
    logic [DIVISOR_W-1:0]  rem_next;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign rem_next  = rem_ge ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], rem_ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/interpolated_curve_table.sv
// Piecewise linear curve table: stores unsorted (date, value) points and
// answers value-at-date queries.
// Input channel (s_*): one transfer per item. s_tuser selects the operation
// (0 adds a point, 1 queries), s_tdata carries the date and the Q8.24 value.
// Result channel (m_*): exactly one transfer per item, with the value in
// m_tdata and a status code in m_tuser.
// An add, or a query on an empty table, goes from idle straight to the
// result step. A query scans the date memory at most once, one entry per
// cycle, and stops early on an exact match; a clamp or a match then reads
// one value, while an interpolation reads two, multiplies and runs the
// bit-serial divider, which produces one of its 55 quotient bits per
// cycle.
// Only one item is in flight; s_tready is high while the block is idle.
// A finished result sits in the output register until m_tready takes it;
// the next item is accepted meanwhile and waits at its result step.
// Reset empties the table (count, earliest and latest index go to zero);
// the memories are not cleared, since entries at or beyond the count are
// never read.
`include "assert_macros.svh"

module interpolated_curve_table #(
    parameter int TABLE_DEPTH = ict_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ict_pkg::IN_TDATA_W-1:0] s_tdata,   // point_date, point_value
    input  logic [0:0]                     s_tuser,   // operation
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ict_pkg::VALUE_W-1:0]    m_tdata,   // value_out
    output logic [ict_pkg::STATUS_W-1:0]   m_tuser    // status
);

    import ict_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    state_t state_reg;
    state_t state_next;

    // Table bookkeeping.
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   earliest_idx_reg;
    logic [IDX_W-1:0]   latest_idx_reg;
    logic [DATE_W-1:0]  earliest_date_reg;
    logic [DATE_W-1:0]  latest_date_reg;

    // Scan state.
    logic [DATE_W-1:0]  q_date_reg;
    logic [CNT_W-1:0]   issue_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               have_below_reg;
    logic               have_above_reg;
    logic [IDX_W-1:0]   below_idx_reg;
    logic [IDX_W-1:0]   above_idx_reg;
    logic [DATE_W-1:0]  below_date_reg;
    logic [DATE_W-1:0]  above_date_reg;
    logic [IDX_W-1:0]   one_idx_reg;

    // Interpolation datapath.
    logic signed [VALUE_W-1:0] vb_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [DATE_W-1:0]         dq_reg;
    logic [DATE_W-1:0]         den_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;

    // Pending result and output register.
    logic [VALUE_W-1:0]  res_value_reg;
    status_t             res_status_reg;
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    status_t             m_status_reg;

    logic               in_fire;
    logic               in_op;
    logic [DATE_W-1:0]  in_date;
    logic [VALUE_W-1:0] in_value;
    logic               table_full;
    logic               add_write;
    logic               issue_en;
    logic               cmp_hit;
    logic               scan_end;
    logic               out_free;

    logic [DATE_W-1:0]  date_rd;
    logic [VALUE_W-1:0] value_rd;
    logic [IDX_W-1:0]   value_rd_addr;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [MAG_W-1:0]   div_quot;
    logic [PROD_W-1:0]  prod_abs;

    logic signed [QUOT_W:0] quot_s;
    logic signed [QUOT_W:0] quot_adj;
    logic signed [QUOT_W:0] vb_ext;
    logic signed [QUOT_W:0] interp_sum;

    assign in_op    = s_tuser[0];
    assign in_date  = s_tdata[DATE_W-1:0];
    assign in_value = s_tdata[DATE_W+VALUE_W-1:DATE_W];

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign table_full = (count_reg == DEPTH_CNT);
    assign add_write  = in_fire && (in_op == OP_ADD) && !table_full;
    assign out_free   = !m_tvalid_reg || m_tready;

    // The scan issues one date read per cycle; the compare follows in the next
    // cycle, when the registered read data comes back.
    assign issue_en = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign cmp_hit  = cmp_valid_reg && (date_rd == q_date_reg);
    assign scan_end = (state_reg == S_SCAN) && !issue_en && !cmp_valid_reg;

    // Writes happen only in the idle state and read data is used only during a
    // query, so a read of an entry that is being written is never used.
    ict_ram #(
        .WIDTH (DATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_date_ram (
        .aclk    (aclk),
        .wr_en   (add_write),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_date),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (date_rd)
    );

    always_comb begin
        case (state_reg)
            S_RD_VB: value_rd_addr = below_idx_reg;
            S_RD_VA: value_rd_addr = above_idx_reg;
            default: value_rd_addr = one_idx_reg;
        endcase
    end

    ict_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (add_write),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_value),
        .rd_addr (value_rd_addr),
        .rd_data (value_rd)
    );

    // The quotient is truncated toward zero: divide magnitudes and put the
    // sign back afterwards.
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_start = (state_reg == S_DIV_START);

    ict_div #(
        .DIVIDEND_W (MAG_W),
        .DIVISOR_W  (DATE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot_s     = $signed({1'b0, div_quot[QUOT_W-1:0]});
    assign quot_adj   = neg_reg ? -quot_s : quot_s;
    assign vb_ext     = $signed({{2{vb_reg[VALUE_W-1]}}, vb_reg});
    assign interp_sum = vb_ext + quot_adj;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_ADD || count_reg == '0) begin
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cmp_hit) begin
                    state_next = S_RD_ONE;
                end else if (scan_end) begin
                    if (!have_below_reg || !have_above_reg) begin
                        state_next = S_RD_ONE;
                    end else begin
                        state_next = S_RD_VB;
                    end
                end
            end
            S_RD_ONE:    state_next = S_GET_ONE;
            S_GET_ONE:   state_next = S_RESULT;
            S_RD_VB:     state_next = S_GET_VB;
            S_GET_VB:    state_next = S_RD_VA;
            S_RD_VA:     state_next = S_GET_VA;
            S_GET_VA:    state_next = S_MUL;
            S_MUL:       state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = S_ADD;
                end
            end
            S_ADD:       state_next = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            earliest_idx_reg <= '0;
            latest_idx_reg   <= '0;
            cmp_valid_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (add_write) begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == '0) begin
                    earliest_idx_reg <= '0;
                    latest_idx_reg   <= '0;
                end else if (in_date < earliest_date_reg) begin
                    earliest_idx_reg <= count_reg[IDX_W-1:0];
                end else if (in_date > latest_date_reg) begin
                    latest_idx_reg <= count_reg[IDX_W-1:0];
                end
            end
            cmp_valid_reg <= issue_en;
            if (state_reg == S_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        // Copies of the extreme dates spare a memory read on every add.
        if (add_write) begin
            if (count_reg == '0) begin
                earliest_date_reg <= in_date;
                latest_date_reg   <= in_date;
            end else if (in_date < earliest_date_reg) begin
                earliest_date_reg <= in_date;
            end else if (in_date > latest_date_reg) begin
                latest_date_reg <= in_date;
            end
        end

        if (state_reg == S_IDLE) begin
            issue_reg      <= '0;
            have_below_reg <= 1'b0;
            have_above_reg <= 1'b0;
            if (in_fire) begin
                q_date_reg    <= in_date;
                res_value_reg <= '0;
                if (in_op == OP_ADD) begin
                    res_status_reg <= table_full ? ST_FULL : ST_STORED;
                end else begin
                    res_status_reg <= ST_EMPTY;
                end
            end
        end

        if (issue_en) begin
            issue_reg   <= issue_reg + CNT_W'(1);
            cmp_idx_reg <= issue_reg[IDX_W-1:0];
        end

        // Nearest neighbours use strict compares so that the first entry of
        // a repeated date wins.
        if (state_reg == S_SCAN && cmp_valid_reg) begin
            if (cmp_hit) begin
                one_idx_reg    <= cmp_idx_reg;
                res_status_reg <= ST_EXACT;
            end else if (date_rd < q_date_reg) begin
                if (!have_below_reg || date_rd > below_date_reg) begin
                    have_below_reg <= 1'b1;
                    below_idx_reg  <= cmp_idx_reg;
                    below_date_reg <= date_rd;
                end
            end else begin
                if (!have_above_reg || date_rd < above_date_reg) begin
                    have_above_reg <= 1'b1;
                    above_idx_reg  <= cmp_idx_reg;
                    above_date_reg <= date_rd;
                end
            end
        end

        if (scan_end) begin
            if (!have_below_reg) begin
                one_idx_reg    <= earliest_idx_reg;
                res_status_reg <= ST_CLAMP_LOW;
            end else if (!have_above_reg) begin
                one_idx_reg    <= latest_idx_reg;
                res_status_reg <= ST_CLAMP_HIGH;
            end else begin
                res_status_reg <= ST_INTERP;
            end
        end

        case (state_reg)
            S_GET_ONE: res_value_reg <= value_rd;
            S_GET_VB:  vb_reg <= $signed(value_rd);
            S_GET_VA: begin
                diff_reg <= $signed({value_rd[VALUE_W-1], value_rd})
                          - $signed({vb_reg[VALUE_W-1], vb_reg});
                dq_reg   <= q_date_reg - below_date_reg;
                den_reg  <= above_date_reg - below_date_reg;
            end
            S_MUL:       prod_reg <= diff_reg * $signed({1'b0, dq_reg});
            S_DIV_START: neg_reg <= prod_reg[PROD_W-1];
            S_ADD:       res_value_reg <= interp_sum[VALUE_W-1:0];
            default: begin
            end
        endcase

        if (state_reg == S_RESULT && out_free) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    // The fill count never passes the table depth.
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT)
    // A scan only ever runs over a non-empty table.
    `ASSERT_IMPLIES(a_scan_nonempty, aclk, aresetn, state_reg == S_SCAN, count_reg != '0)
    // The divider is never restarted while it is still working.
    `ASSERT_IMPLIES(a_div_start_idle, aclk, aresetn, div_start, !div_busy)
    // A quotient only arrives while the sequencer is waiting for it.
    `ASSERT_IMPLIES(a_div_done_wait, aclk, aresetn, div_done, state_reg == S_DIV_WAIT)

endmodule
